FILE: sv/sha_pkg.sv
package sha_pkg;

   // Request and response payloads
   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       is_last;
   } sha_req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } sha_rsp_type;

   // Classified request as held in the queue; idle requests never enter it
   typedef enum logic [1:0] {
      OP_BYTE,
      OP_FINISH,
      OP_BYTE_FINISH
   } sha_op_type;

   typedef struct packed {
      sha_op_type op;
      logic [7:0] data_byte;
   } sha_cmd_type;

   typedef struct packed {
      logic        valid;
      sha_cmd_type cmd;
   } sha_queue_type;

   // Back end sequencer states
   typedef enum logic [2:0] {
      ST_ABSORB,
      ST_PAD,
      ST_PAD_EXTRA,
      ST_ROUND,
      ST_UPDATE,
      ST_OUTPUT
   } sha_state_type;

   localparam logic [7:0] PAD_BYTE = 8'h80;
   // last byte position whose pad still leaves room for the length field
   localparam logic [5:0] LAST_SHORT_PAD = 6'd55;
   localparam logic [5:0] LAST_ROUND = 6'd63;
   localparam logic [5:0] LAST_BYTE_POS = 6'd63;

   localparam logic [31:0] SHA_IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] SHA_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

endpackage

FILE: sv/sha256_byte_stream_hasher.sv
// Flow: an accepted request is queued, and the back end absorbs it from the queue head; a full
//   block holds the back end through its compression rounds and the chain update.
// Finishing pads the block and compresses it (a second padded block when the length
//   spills into an extra block), then gives eight digest words, one per accepted response.
// Throughput: one byte per cycle while the back end absorbs; each 64th byte stalls it for the
//   single shared round unit. Reset is synchronous: queue empty, chain at the initial value.
module sha256_byte_stream_hasher
   import sha_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  sha_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output sha_rsp_type rsp_data
);

   sha_queue_type queue_head;
   logic          queue_pop;

   // request classification and queue
   sha_front #(
      .DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_head (queue_head),
      .queue_pop  (queue_pop)
   );

   // absorption, padding, compression and digest output
   sha_back u_back (
      .clock      (clock),
      .reset      (reset),
      .queue_head (queue_head),
      .queue_pop  (queue_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

FILE: sv/sha_front.sv
module sha_front
   import sha_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  sha_req_type   req_data,
   output sha_queue_type queue_head,
   input  logic          queue_pop
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   sha_cmd_type      slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;
   sha_cmd_type      cmd;

   // classify the request; an idle request is taken and dropped
   always_comb begin
      cmd.data_byte = req_data.data_byte;
      unique case ({req_data.has_byte, req_data.is_last})
         2'b10:   cmd.op = OP_BYTE;
         2'b01:   cmd.op = OP_FINISH;
         2'b11:   cmd.op = OP_BYTE_FINISH;
         default: cmd.op = OP_BYTE;
      endcase
   end

   assign req_ready = (count_ff != FULL_COUNT);
   assign push = req_valid && req_ready && (req_data.has_byte || req_data.is_last);
   assign pop = queue_pop && (count_ff != '0);

   assign queue_head.valid = (count_ff != '0);
   assign queue_head.cmd   = slot_ff[rd_ff];

   // queue pointers and occupancy
   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == LAST_PTR) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == LAST_PTR) ? '0 : rd_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= cmd;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("queue occupancy beyond depth");

   a_idle_dropped: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_data.has_byte && !req_data.is_last && !pop)
      |=> (count_ff == $past(count_ff)))
      else $error("idle request entered the queue");

   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queued request not counted");
`endif

endmodule

FILE: sv/sha_back.sv
module sha_back
   import sha_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  sha_queue_type queue_head,
   output logic          queue_pop,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output sha_rsp_type   rsp_data
);

   sha_state_type state_ff, state_in;
   logic [31:0]   w_ff [16];
   logic [31:0]   w_in [16];
   logic [31:0]   chain_ff [8];
   logic [31:0]   chain_in [8];
   logic [31:0]   v_ff [8];
   logic [31:0]   v_in [8];
   logic [5:0]    fill_ff, fill_in;
   logic [5:0]    round_ff, round_in;
   logic [63:0]   bits_ff, bits_in;
   logic [2:0]    idx_ff, idx_in;
   logic          pend_ff, pend_in;
   logic          extra_ff, extra_in;
   logic          final_ff, final_in;

   logic [31:0]   big0, big1, ch, maj, t1, t2, s0, s1, w_next;
   logic [4:0]    lane_off;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // one compression round and one schedule word
   always_comb begin
      big1 = rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25);
      ch   = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1   = v_ff[7] + big1 + ch + SHA_K[round_ff] + w_ff[0];
      big0 = rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22);
      maj  = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2   = big0 + maj;
      s0   = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1   = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      w_next = s1 + w_ff[9] + s0 + w_ff[0];
   end

   // big-endian lane of the byte at the fill position
   assign lane_off = {~fill_ff[1:0], 3'b000};

   // sequencer: absorb, pad, rounds, chain update, digest out
   always_comb begin
      logic [5:0] pos;
      state_in = state_ff;
      w_in = w_ff;
      chain_in = chain_ff;
      v_in = v_ff;
      fill_in = fill_ff;
      round_in = round_ff;
      bits_in = bits_ff;
      idx_in = idx_ff;
      pend_in = pend_ff;
      extra_in = extra_ff;
      final_in = final_ff;
      queue_pop = 1'b0;
      pos = '0;
      unique case (state_ff)
         ST_ABSORB: begin
            if (queue_head.valid) begin
               queue_pop = 1'b1;
               unique case (queue_head.cmd.op) inside
                  OP_BYTE, OP_BYTE_FINISH: begin
                     w_in[fill_ff[5:2]][lane_off +: 8] = queue_head.cmd.data_byte;
                     fill_in = fill_ff + 6'd1;
                     bits_in = bits_ff + 64'd8;
                     if (fill_ff == LAST_BYTE_POS) begin
                        // block full: compress, pad afterwards if this ends it
                        v_in = chain_ff;
                        round_in = '0;
                        pend_in = (queue_head.cmd.op == OP_BYTE_FINISH);
                        state_in = ST_ROUND;
                     end else if (queue_head.cmd.op == OP_BYTE_FINISH) begin
                        state_in = ST_PAD;
                     end
                  end
                  OP_FINISH: begin
                     state_in = ST_PAD;
                  end
                  default: begin
                     state_in = ST_ABSORB;
                  end
               endcase
            end
         end
         ST_PAD: begin
            // pad byte at the fill position, zeros above it
            for (int wi = 0; wi < 16; wi++) begin
               for (int li = 0; li < 4; li++) begin
                  pos = {4'(wi), 2'(li)};
                  if (pos == fill_ff) begin
                     w_in[wi][8 * (3 - li) +: 8] = PAD_BYTE;
                  end else if (pos > fill_ff) begin
                     w_in[wi][8 * (3 - li) +: 8] = 8'h00;
                  end
               end
            end
            if (fill_ff <= LAST_SHORT_PAD) begin
               w_in[14] = bits_ff[63:32];
               w_in[15] = bits_ff[31:0];
               final_in = 1'b1;
            end else begin
               extra_in = 1'b1;
            end
            v_in = chain_ff;
            round_in = '0;
            state_in = ST_ROUND;
         end
         ST_PAD_EXTRA: begin
            for (int wi = 0; wi < 14; wi++) begin
               w_in[wi] = '0;
            end
            w_in[14] = bits_ff[63:32];
            w_in[15] = bits_ff[31:0];
            extra_in = 1'b0;
            final_in = 1'b1;
            v_in = chain_ff;
            round_in = '0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            v_in[0] = t1 + t2;
            v_in[1] = v_ff[0];
            v_in[2] = v_ff[1];
            v_in[3] = v_ff[2];
            v_in[4] = v_ff[3] + t1;
            v_in[5] = v_ff[4];
            v_in[6] = v_ff[5];
            v_in[7] = v_ff[6];
            for (int i = 0; i < 15; i++) begin
               w_in[i] = w_ff[i + 1];
            end
            w_in[15] = w_next;
            round_in = round_ff + 6'd1;
            if (round_ff == LAST_ROUND) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            for (int i = 0; i < 8; i++) begin
               chain_in[i] = chain_ff[i] + v_ff[i];
            end
            if (final_ff) begin
               final_in = 1'b0;
               idx_in = '0;
               state_in = ST_OUTPUT;
            end else if (pend_ff) begin
               pend_in = 1'b0;
               state_in = ST_PAD;
            end else if (extra_ff) begin
               state_in = ST_PAD_EXTRA;
            end else begin
               state_in = ST_ABSORB;
            end
         end
         ST_OUTPUT: begin
            if (rsp_ready) begin
               // rotate the next word to the front
               for (int i = 0; i < 7; i++) begin
                  chain_in[i] = chain_ff[i + 1];
               end
               chain_in[7] = chain_ff[0];
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  chain_in = SHA_IV;
                  fill_in = '0;
                  bits_in = '0;
                  state_in = ST_ABSORB;
               end
            end
         end
         default: begin
            state_in = ST_ABSORB;
         end
      endcase
   end

   // control and chaining state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ABSORB;
         chain_ff <= SHA_IV;
         fill_ff <= '0;
         round_ff <= '0;
         bits_ff <= '0;
         idx_ff <= '0;
         pend_ff <= 1'b0;
         extra_ff <= 1'b0;
         final_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         chain_ff <= chain_in;
         fill_ff <= fill_in;
         round_ff <= round_in;
         bits_ff <= bits_in;
         idx_ff <= idx_in;
         pend_ff <= pend_in;
         extra_ff <= extra_in;
         final_ff <= final_in;
      end
   end

   // block words and working variables
   always_ff @(posedge clock) begin
      w_ff <= w_in;
      v_ff <= v_in;
   end

   assign rsp_valid = (state_ff == ST_OUTPUT);
   assign rsp_data.digest_word = chain_ff[0];
   assign rsp_data.word_index = idx_ff;
   assign rsp_data.last_word = (idx_ff == 3'd7);

`ifndef ASSERT_OFF
   a_round_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && round_ff == LAST_ROUND) |=> (state_ff == ST_UPDATE))
      else $error("compression did not end after the last round");

   a_digest_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE && final_ff) |=> (rsp_valid && rsp_data.word_index == 3'd0))
      else $error("digest did not start at word zero");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_data.last_word)
      |=> (chain_ff[0] == SHA_IV[0] && fill_ff == '0 && bits_ff == '0
           && state_ff == ST_ABSORB))
      else $error("hasher not restarted after digest");

   a_pad_flags: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> !(pend_ff && final_ff))
      else $error("pending pad alongside final block");
`endif

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps

module tb
   import sha_pkg::*;
();

   // SHA-256 round constants and initial hash value, FIPS 180-4
   localparam logic [31:0] ROUND_CONST [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam int LONG_HOLD_CYCLES = 600;
   localparam int HOLD_AFTER_WORDS = 48;
   localparam int ITEM_TARGET = 140;
   localparam int DRAIN_CYCLES = 300;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   sha_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   sha_rsp_type rsp_data;

   sha256_byte_stream_hasher i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Hash state mirrored by the predictor
   logic [31:0] hash_chain [8];
   logic [7:0]  block_buf [64];
   int          buf_fill;
   logic [63:0] bit_count;

   sha_req_type stim_q [$];
   sha_rsp_type expected_words [$];

   int error_count = 0;
   int accepted_count = 0;
   int words_seen = 0;
   int msg_count = 0;
   int byte_count = 0;
   int block_count = 0;
   int extra_pad_count = 0;
   int queued_items = 0;

   function automatic logic [31:0] rotr32(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // One SHA-256 compression of block_buf into hash_chain
   function automatic void compress_buffer();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] s0, s1, t1, t2, ch, mj;
      for (int t = 0; t < 16; t++)
         w[t] = {block_buf[4*t], block_buf[4*t+1], block_buf[4*t+2], block_buf[4*t+3]};
      for (int t = 16; t < 64; t++) begin
         s0 = rotr32(w[t-15], 7) ^ rotr32(w[t-15], 18) ^ (w[t-15] >> 3);
         s1 = rotr32(w[t-2], 17) ^ rotr32(w[t-2], 19) ^ (w[t-2] >> 10);
         w[t] = s1 + w[t-7] + s0 + w[t-16];
      end
      v = hash_chain;
      for (int t = 0; t < 64; t++) begin
         s1 = rotr32(v[4], 6) ^ rotr32(v[4], 11) ^ rotr32(v[4], 25);
         ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
         t1 = v[7] + s1 + ch + ROUND_CONST[t] + w[t];
         s0 = rotr32(v[0], 2) ^ rotr32(v[0], 13) ^ rotr32(v[0], 22);
         mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
         t2 = s0 + mj;
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++)
         hash_chain[i] = hash_chain[i] + v[i];
      block_count++;
   endfunction

   function automatic void restart_hash();
      hash_chain = INIT_HASH;
      buf_fill = 0;
      bit_count = '0;
   endfunction

   // Absorb one accepted request; a last request queues the eight digest words
   function automatic void absorb_request(sha_req_type r);
      int k;
      sha_rsp_type dw;
      if (r.has_byte) begin
         block_buf[buf_fill] = r.data_byte;
         buf_fill++;
         bit_count = bit_count + 64'd8;
         byte_count++;
         if (buf_fill == 64) begin
            compress_buffer();
            buf_fill = 0;
         end
      end
      if (!r.is_last)
         return;
      k = buf_fill;
      block_buf[k] = 8'h80;
      k++;
      // no room for the length field: pad out and spend one more block
      if (k > 56) begin
         while (k < 64) begin
            block_buf[k] = 8'h00;
            k++;
         end
         compress_buffer();
         extra_pad_count++;
         k = 0;
      end
      while (k < 56) begin
         block_buf[k] = 8'h00;
         k++;
      end
      for (int i = 0; i < 8; i++)
         block_buf[56+i] = bit_count[63-8*i -: 8];
      compress_buffer();
      for (int i = 0; i < 8; i++) begin
         dw.digest_word = hash_chain[i];
         dw.word_index = 3'(i);
         dw.last_word = (i == 7);
         expected_words.push_back(dw);
      end
      msg_count++;
      restart_hash();
   endfunction

   function automatic void push_req(logic [7:0] data, logic has, logic last);
      sha_req_type r;
      r.data_byte = data;
      r.has_byte = has;
      r.is_last = last;
      stim_q.push_back(r);
      queued_items++;
   endfunction

   // Queue a whole message with random bytes and a sprinkle of idle requests
   function automatic void queue_message(int len, bit last_on_byte);
      bit close_on_byte;
      close_on_byte = last_on_byte && (len > 0);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0)
            push_req(8'($urandom), 1'b0, 1'b0);
         push_req(8'($urandom), 1'b1, close_on_byte && (i == len - 1));
      end
      if (!close_on_byte)
         push_req(8'($urandom), 1'b0, 1'b1);
   endfunction

   task automatic wait_drained();
      do
         @(negedge clock);
      while (stim_q.size() != 0 || req_valid || expected_words.size() != 0);
   endtask

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Request driver: bursts of random length separated by random gaps
   int burst_left = 1;
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 1;
         gap_left = 0;
      end else begin
         if (req_valid && req_ready) begin
            absorb_request(req_data);
            accepted_count++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (stim_q.size() > 0) begin
               req_data <= stim_q.pop_front();
               req_valid <= 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and receiver stall pattern
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   int  pattern_count = 0;
   int  rx_mode = 0;

   always @(posedge clock) begin : rx_side
      sha_rsp_type want;
      logic next_ready;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            words_seen++;
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected digest word, expected none, got %h idx %0d last %b",
                        $time, rsp_data.digest_word, rsp_data.word_index, rsp_data.last_word);
               error_count++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_data.digest_word !== want.digest_word) begin
                  $display("%0t: digest_word mismatch, expected %h, got %h",
                           $time, want.digest_word, rsp_data.digest_word);
                  error_count++;
               end
               if (rsp_data.word_index !== want.word_index) begin
                  $display("%0t: word_index mismatch, expected %0d, got %0d",
                           $time, want.word_index, rsp_data.word_index);
                  error_count++;
               end
               if (rsp_data.last_word !== want.last_word) begin
                  $display("%0t: last_word mismatch, expected %b, got %b",
                           $time, want.last_word, rsp_data.last_word);
                  error_count++;
               end
            end
         end
         // pick a new random stall mode
         pattern_count++;
         if (pattern_count % 32 == 0)
            rx_mode = $urandom_range(0, 2);
         if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
         end else if (!hold_done && words_seen >= HOLD_AFTER_WORDS) begin
            // one long hold-off so the block backs up onto its input
            hold_done = 1'b1;
            hold_left = LONG_HOLD_CYCLES;
            next_ready = 1'b0;
         end else begin
            case (rx_mode)
               0: next_ready = 1'b1;
               1: next_ready = ($urandom_range(0, 1) == 0);
               default: next_ready = ($urandom_range(0, 3) == 0);
            endcase
         end
         rsp_ready <= next_ready;
      end
   end

   // Stimulus and end of run
   initial begin
      restart_hash();
      for (int i = 0; i < 64; i++)
         block_buf[i] = 8'h00;

      // directed: idle requests, empty messages, single bytes, short messages
      push_req(8'h00, 1'b0, 1'b0);
      push_req(8'h00, 1'b0, 1'b1);
      push_req(8'hff, 1'b0, 1'b0);
      push_req(8'hff, 1'b0, 1'b1);
      push_req(8'h00, 1'b1, 1'b1);
      push_req(8'hff, 1'b1, 1'b1);
      push_req(8'h61, 1'b1, 1'b0);
      push_req(8'h62, 1'b1, 1'b0);
      push_req(8'h63, 1'b1, 1'b0);
      push_req(8'h00, 1'b0, 1'b1);
      push_req(8'hff, 1'b1, 1'b0);
      push_req(8'h5a, 1'b0, 1'b0);
      push_req(8'h00, 1'b1, 1'b0);
      push_req(8'ha5, 1'b1, 1'b1);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // sender pauses until every digest is out
      wait_drained();

      // length spills into an extra block, then a full block closed on its last byte;
      // the receiver is in its long hold-off by now, so the queue backs up
      queue_message(56, 1'b0);
      queue_message(64, 1'b1);

      wait_drained();

      // short random messages up to the item budget
      while (queued_items < ITEM_TARGET)
         queue_message($urandom_range(0, 12), $urandom_range(0, 1));

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Hashed %0d messages, %0d bytes, %0d blocks (%0d extra padding blocks)",
               msg_count, byte_count, block_count, extra_pad_count);
      $display("Requests accepted: %0d, digest words checked: %0d, mismatches: %0d",
               accepted_count, words_seen, error_count);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("Timed out with %0d digest words outstanding", expected_words.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
